// ===== rtl/lbm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the D3Q15 collide/stream block.
// Used by every module of the block; depends on nothing.
package lbm_pkg;

	localparam int LBM_DW         = 32;
	localparam int LBM_FRAC       = 28;
	localparam int LBM_NUM_DIRS   = 15;
	localparam int LBM_NX_MAX     = 256;
	localparam int LBM_NY_MAX     = 256;
	localparam int LBM_FIFO_DEPTH = 4;

	localparam logic signed [31:0] Q_MAX        = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN        = 32'sh80000000;
	localparam logic signed [31:0] Q_ONE        = 32'sd268435456;
	localparam logic signed [31:0] Q_HALF       = 32'sd134217728;
	localparam logic signed [31:0] Q_THREE_HALF = 32'sd402653184;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_RELAX  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [3:0] DIR_LAST = 4'd14;
	localparam logic [3:0] DIR_NONE = 4'd15;

	typedef logic [3:0] dir_t;

	typedef struct packed {
		logic [7:0]         node_x;
		logic [7:0]         node_y;
		logic [7:0]         node_z;
		dir_t               speed;
		logic signed [31:0] value;
		logic               solid;
		logic               boundary;
		logic signed [31:0] bc;
		logic               last;
	} lbm_item_t;

	typedef struct packed {
		logic [29:0] relax;
		logic [8:0]  width;
		logic [8:0]  height;
	} lbm_cfg_t;

	function automatic logic signed [1:0] dir_x(input dir_t k);
		logic signed [1:0] r;
		case (k) inside
			4'd1, 4'd7, 4'd9, 4'd11, 4'd13:  r = 2'sb01;
			4'd2, 4'd8, 4'd10, 4'd12, 4'd14: r = 2'sb11;
			default:                         r = 2'sb00;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] dir_y(input dir_t k);
		logic signed [1:0] r;
		case (k) inside
			4'd3, 4'd7, 4'd8, 4'd11, 4'd12:  r = 2'sb01;
			4'd4, 4'd9, 4'd10, 4'd13, 4'd14: r = 2'sb11;
			default:                         r = 2'sb00;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] dir_z(input dir_t k);
		logic signed [1:0] r;
		case (k) inside
			4'd5, 4'd7, 4'd8, 4'd9, 4'd10:   r = 2'sb01;
			4'd6, 4'd11, 4'd12, 4'd13, 4'd14: r = 2'sb11;
			default:                         r = 2'sb00;
		endcase
		return r;
	endfunction

	// Lattice weights 2/9, 1/9, 1/72 in Q3.28
	function automatic logic signed [31:0] dir_weight(input dir_t k);
		logic signed [31:0] r;
		case (k) inside
			4'd0:                              r = 32'sd59652324;
			4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: r = 32'sd29826162;
			default:                           r = 32'sd3728270;
		endcase
		return r;
	endfunction

	function automatic dir_t dir_opposite(input dir_t k);
		dir_t r;
		case (k)
			4'd1:    r = 4'd2;
			4'd2:    r = 4'd1;
			4'd3:    r = 4'd4;
			4'd4:    r = 4'd3;
			4'd5:    r = 4'd6;
			4'd6:    r = 4'd5;
			4'd7:    r = 4'd14;
			4'd8:    r = 4'd13;
			4'd9:    r = 4'd12;
			4'd10:   r = 4'd11;
			4'd11:   r = 4'd10;
			4'd12:   r = 4'd9;
			4'd13:   r = 4'd8;
			4'd14:   r = 4'd7;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat_q(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = Q_MAX;
		end else if (v < -40'sd2147483648) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Round a Q7.56 product to nearest (ties away from zero) and saturate to Q3.28
	function automatic logic signed [31:0] round_q(input logic signed [63:0] p);
		logic [63:0]        mag;
		logic [63:0]        rs;
		logic signed [39:0] v;
		mag = p[63] ? 64'(-p) : 64'(p);
		rs  = (mag + 64'd134217728) >> LBM_FRAC;
		v   = $signed({1'b0, rs[38:0]});
		if (p[63]) begin
			v = -v;
		end
		return sat_q(v);
	endfunction

	// One term e*v of a dot product with a lattice direction component
	function automatic logic signed [39:0] dir_term(input logic signed [1:0] e,
	                                                input logic signed [31:0] v);
		logic signed [39:0] ext;
		logic signed [39:0] r;
		ext = $signed({{8{v[31]}}, v});
		if (e == 2'sb01) begin
			r = ext;
		end else if (e == 2'sb11) begin
			r = -ext;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	// sat(3 * (e_k . v))
	function automatic logic signed [31:0] cu_q(input dir_t k, input logic signed [31:0] vx,
	                                            input logic signed [31:0] vy,
	                                            input logic signed [31:0] vz);
		logic signed [39:0] d;
		d = dir_term(dir_x(k), vx) + dir_term(dir_y(k), vy) + dir_term(dir_z(k), vz);
		return sat_q(40'sd3 * d);
	endfunction

endpackage

// ===== rtl/lbm_front.sv =====
// Front end: takes requests, drops undefined directions, tags the node's last direction.
// Depends on lbm_pkg; feeds lbm_fifo.
module lbm_front import lbm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  lbm_item_t item_in,
	output logic      push,
	output lbm_item_t push_item,
	input  logic      fifo_full
);

	logic      valid_s1;
	lbm_item_t item_s1;
	lbm_item_t item_mark;
	logic      accept;

	assign item_stall = valid_s1 && fifo_full;
	assign accept     = item_valid && !item_stall;
	assign push       = valid_s1 && !fifo_full;
	assign push_item  = item_s1;

	// Mark the request that closes a node
	always_comb begin
		item_mark      = item_in;
		item_mark.last = (item_in.speed == DIR_LAST);
	end

	// Hold one classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && item_in.speed != DIR_NONE) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_mark;
		end
	end

endmodule

// ===== rtl/lbm_fifo.sv =====
// Short request queue between the front end and the node engine.
// Depends on lbm_pkg for the request type.
module lbm_fifo import lbm_pkg::*; #(
	parameter int DEPTH = LBM_FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lbm_item_t push_item,
	output logic      full,
	input  logic      pop,
	output lbm_item_t pop_item,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lbm_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/lbm_div.sv =====
// Radix-2 restoring divider for velocity = momentum / density in Q3.28.
// Depends on lbm_pkg; truncates toward zero and saturates, zero divisor gives zero.
module lbm_div import lbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int QW = LBM_DW + LBM_FRAC;
	localparam int NW = $clog2(QW);

	logic [QW-1:0] sh_q;
	logic [32:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic          zero_q;
	logic          run_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;

	logic [32:0]   num_mag;
	logic [32:0]   den_mag;
	logic [32:0]   trial;
	logic          qbit;

	assign num_mag = num[31] ? 33'(-$signed({num[31], num})) : {1'b0, num};
	assign den_mag = den[31] ? 33'(-$signed({den[31], den})) : {1'b0, den};
	assign trial   = {rem_q[31:0], sh_q[QW-1]};
	assign qbit    = (trial >= {1'b0, den_q});
	assign done    = done_q;

	// One quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= NW'(QW - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= {num_mag[31:0], {LBM_FRAC{1'b0}}};
			rem_q  <= '0;
			den_q  <= den_mag[31:0];
			neg_q  <= num[31] ^ den[31];
			zero_q <= (den == '0);
		end else if (run_q) begin
			rem_q <= qbit ? trial - {1'b0, den_q} : trial;
			sh_q  <= {sh_q[QW-2:0], qbit};
		end
	end

	// Apply sign and saturate the magnitude
	always_comb begin
		if (zero_q) begin
			quo = '0;
		end else if (!neg_q) begin
			quo = (sh_q > QW'(32'h7fffffff)) ? Q_MAX : $signed(sh_q[31:0]);
		end else begin
			quo = (sh_q >= QW'(33'h080000000)) ? Q_MIN : -$signed(sh_q[31:0]);
		end
	end

endmodule

// ===== rtl/lbm_back.sv =====
// Node engine: stores a node's directions, computes moments, corrects, collides, streams.
// Depends on lbm_pkg and lbm_div; one shared multiplier serves every product.
module lbm_back import lbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  lbm_cfg_t    cfg,
	input  lbm_item_t   pop_item,
	input  logic        empty,
	output logic        pop,
	input  logic        result_stall,
	output logic        result_valid,
	output logic [7:0]  dest_x,
	output logic [7:0]  dest_y,
	output logic signed [9:0] dest_z,
	output logic [3:0]  out_speed,
	output logic signed [31:0] out_value,
	output logic        last
);

	typedef enum logic [7:0] {
		S_LOAD = 8'b0000_0001,
		S_SUM  = 8'b0000_0010,
		S_DIV  = 8'b0000_0100,
		S_BCP  = 8'b0000_1000,
		S_BC   = 8'b0001_0000,
		S_USQ  = 8'b0010_0000,
		S_COLL = 8'b0100_0000,
		S_EMIT = 8'b1000_0000
	} state_t;

	localparam logic [8:0] NX_LIM = 9'(LBM_NX_MAX);
	localparam logic [8:0] NY_LIM = 9'(LBM_NY_MAX);

	state_t             state_q;
	dir_t               k_q;
	logic [3:0]         sub_q;
	logic [1:0]         comp_q;

	logic signed [31:0] f_q [LBM_NUM_DIRS];
	logic signed [31:0] w_q [LBM_NUM_DIRS];
	logic signed [35:0] rho_acc_q, jx_acc_q, jy_acc_q, jz_acc_q;
	logic signed [31:0] rho_q, jx_q, jy_q, jz_q;
	logic signed [31:0] ux_q, uy_q, uz_q;
	logic signed [31:0] dx_q, dy_q, dz_q;
	logic signed [31:0] cu_reg_q, tmp_q, rw_q, p15_q;
	logic signed [33:0] usq_acc_q;
	logic [7:0]         nx_q, ny_q, nz_q;
	logic               solid_q, bnd_q;
	logic signed [31:0] bc_q;
	logic signed [63:0] prod_s1;

	logic               out_valid_q;
	logic [7:0]         out_x_q, out_y_q;
	logic signed [9:0]  out_z_q;
	dir_t               out_k_q;
	logic signed [31:0] out_v_q;
	logic               out_last_q;

	dir_t               rd_idx;
	logic signed [31:0] f_rd;
	logic signed [35:0] rho_nx, jx_nx, jy_nx, jz_nx;
	logic signed [31:0] rnd;
	logic signed [31:0] mul_a, mul_b;
	logic signed [31:0] cu_coll, cu_bc, poly, dd, usq;
	logic               div_start, div_done;
	logic signed [31:0] div_num, div_quo;
	logic               emit_load;

	function automatic logic [7:0] wrap(input logic [7:0] n, input logic signed [1:0] e,
	                                    input logic [8:0] reg_w, input logic [8:0] lim);
		logic [8:0]        w;
		logic signed [9:0] v;
		logic signed [9:0] r;
		w = (reg_w < lim) ? reg_w : lim;
		v = $signed({2'b00, n}) + 10'(e);
		if (v < 0) begin
			r = $signed({1'b0, w}) - 10'sd1;
		end else if (v == $signed({1'b0, w})) begin
			r = '0;
		end else begin
			r = v;
		end
		return r[7:0];
	endfunction

	// Read port: stored values while summing, working copy afterwards;
	// bounce-back reads the opposite direction while streaming
	assign rd_idx = (state_q == S_EMIT && solid_q) ? dir_opposite(k_q) : k_q;
	assign f_rd   = (state_q == S_SUM) ? f_q[rd_idx] : w_q[rd_idx];

	assign rho_nx = rho_acc_q + 36'($signed({{4{f_rd[31]}}, f_rd}));
	assign jx_nx  = jx_acc_q + 36'(dir_term(dir_x(k_q), f_rd));
	assign jy_nx  = jy_acc_q + 36'(dir_term(dir_y(k_q), f_rd));
	assign jz_nx  = jz_acc_q + 36'(dir_term(dir_z(k_q), f_rd));

	assign rnd     = round_q(prod_s1);
	assign cu_coll = cu_q(k_q, ux_q, uy_q, uz_q);
	assign cu_bc   = cu_q(k_q, dx_q, dy_q, dz_q);
	assign poly    = sat_q(40'(Q_ONE) + 40'(cu_reg_q) + 40'(tmp_q) - 40'(p15_q));
	assign dd      = sat_q(40'(f_rd) - 40'(tmp_q));
	assign usq     = sat_q(40'(usq_acc_q));

	assign div_start = (state_q == S_DIV) && (sub_q == 4'd0);
	always_comb begin
		case (comp_q)
			2'd0:    div_num = jx_q;
			2'd1:    div_num = jy_q;
			default: div_num = jz_q;
		endcase
	end

	lbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (rho_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_BC: begin
				if (sub_q == 4'd0) begin
					mul_a = dir_weight(k_q);
					mul_b = rho_q;
				end else begin
					mul_a = rw_q;
					mul_b = cu_reg_q;
				end
			end
			S_USQ: begin
				case (sub_q)
					4'd0:    begin mul_a = ux_q; mul_b = ux_q; end
					4'd2:    begin mul_a = uy_q; mul_b = uy_q; end
					4'd4:    begin mul_a = uz_q; mul_b = uz_q; end
					default: begin mul_a = Q_THREE_HALF; mul_b = usq; end
				endcase
			end
			S_COLL: begin
				case (sub_q)
					4'd0:    begin mul_a = cu_coll; mul_b = cu_coll; end
					4'd2:    begin mul_a = Q_HALF; mul_b = tmp_q; end
					4'd4:    begin mul_a = dir_weight(k_q); mul_b = rho_q; end
					4'd6:    begin mul_a = rw_q; mul_b = poly; end
					default: begin mul_a = $signed({2'b00, cfg.relax}); mul_b = dd; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign pop       = (state_q == S_LOAD) && !empty;
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !result_stall);

	// Node sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			k_q     <= '0;
			sub_q   <= '0;
			comp_q  <= '0;
			nx_q    <= '0;
			ny_q    <= '0;
			nz_q    <= '0;
			solid_q <= 1'b0;
			bnd_q   <= 1'b0;
			bc_q    <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (pop) begin
						nx_q    <= pop_item.node_x;
						ny_q    <= pop_item.node_y;
						nz_q    <= pop_item.node_z;
						solid_q <= pop_item.solid;
						bnd_q   <= pop_item.boundary;
						bc_q    <= pop_item.bc;
						if (pop_item.last) begin
							state_q <= S_SUM;
							k_q     <= '0;
						end
					end
				end
				S_SUM: begin
					k_q <= k_q + 4'd1;
					if (k_q == DIR_LAST) begin
						state_q <= S_DIV;
						comp_q  <= '0;
						sub_q   <= '0;
					end
				end
				S_DIV: begin
					if (sub_q == 4'd0) begin
						sub_q <= 4'd1;
					end else if (div_done) begin
						sub_q  <= '0;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							k_q <= '0;
							if (bnd_q) begin
								state_q <= S_BCP;
							end else if (solid_q) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_USQ;
							end
						end
					end
				end
				S_BCP: begin
					state_q <= S_BC;
					k_q     <= 4'd1;
					sub_q   <= '0;
				end
				S_BC: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q == 4'd3) begin
						sub_q <= '0;
						k_q   <= k_q + 4'd1;
						if (k_q == DIR_LAST) begin
							k_q     <= '0;
							state_q <= solid_q ? S_EMIT : S_USQ;
						end
					end
				end
				S_USQ: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q == 4'd7) begin
						sub_q   <= '0;
						k_q     <= '0;
						state_q <= S_COLL;
					end
				end
				S_COLL: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q == 4'd9) begin
						sub_q <= '0;
						k_q   <= k_q + 4'd1;
						if (k_q == DIR_LAST) begin
							k_q     <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						k_q <= k_q + 4'd1;
						if (k_q == DIR_LAST) begin
							k_q     <= '0;
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				if (pop) begin
					f_q[pop_item.speed] <= pop_item.value;
				end
				rho_acc_q <= '0;
				jx_acc_q  <= '0;
				jy_acc_q  <= '0;
				jz_acc_q  <= '0;
			end
			S_SUM: begin
				w_q[k_q]  <= f_rd;
				rho_acc_q <= rho_nx;
				jx_acc_q  <= jx_nx;
				jy_acc_q  <= jy_nx;
				jz_acc_q  <= jz_nx;
				rho_q     <= sat_q(40'(rho_nx));
				jx_q      <= sat_q(40'(jx_nx));
				jy_q      <= sat_q(40'(jy_nx));
				jz_q      <= sat_q(40'(jz_nx));
			end
			S_DIV: begin
				if (sub_q != 4'd0 && div_done) begin
					case (comp_q)
						2'd0:    ux_q <= div_quo;
						2'd1:    uy_q <= div_quo;
						default: uz_q <= div_quo;
					endcase
				end
			end
			S_BCP: begin
				dx_q <= sat_q(-40'(ux_q));
				dy_q <= sat_q(-40'(uy_q));
				dz_q <= sat_q(40'(bc_q) - 40'(uz_q));
			end
			S_BC: begin
				if (sub_q == 4'd1) begin
					rw_q     <= rnd;
					cu_reg_q <= cu_bc;
				end
				if (sub_q == 4'd3) begin
					w_q[k_q] <= sat_q(40'(f_rd) + 40'(rnd));
					if (k_q == DIR_LAST) begin
						ux_q <= '0;
						uy_q <= '0;
						uz_q <= bc_q;
					end
				end
			end
			S_USQ: begin
				case (sub_q)
					4'd1:    usq_acc_q <= 34'(rnd);
					4'd3:    usq_acc_q <= usq_acc_q + 34'(rnd);
					4'd5:    usq_acc_q <= usq_acc_q + 34'(rnd);
					4'd7:    p15_q <= rnd;
					default: ;
				endcase
			end
			S_COLL: begin
				case (sub_q)
					4'd0:    cu_reg_q <= cu_coll;
					4'd1:    tmp_q <= rnd;
					4'd3:    tmp_q <= rnd;
					4'd5:    rw_q <= rnd;
					4'd7:    tmp_q <= rnd;
					4'd9:    w_q[k_q] <= sat_q(40'(f_rd) - 40'(rnd));
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Output register: hold a stalled result, load the next streamed direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_x_q    <= wrap(nx_q, dir_x(k_q), cfg.width, NX_LIM);
			out_y_q    <= wrap(ny_q, dir_y(k_q), cfg.height, NY_LIM);
			out_z_q    <= $signed({2'b00, nz_q}) + 10'(dir_z(k_q));
			out_k_q    <= k_q;
			out_v_q    <= f_rd;
			out_last_q <= (k_q == DIR_LAST);
		end
	end

	assign result_valid = out_valid_q;
	assign dest_x       = out_x_q;
	assign dest_y       = out_y_q;
	assign dest_z       = out_z_q;
	assign out_speed    = out_k_q;
	assign out_value    = out_v_q;
	assign last         = out_last_q;

endmodule

// ===== rtl/lbm_d3q15_collide_stream.sv =====
// Channel   | handshake                 | payload
// request   | item_valid / item_stall   | node_x/y/z, speed_index, dist_value, flags, bc_velocity
// result    | result_valid / result_stall | dest_x/y/z, out_speed, out_value, last
// config    | APB psel/penable/pwrite   | relax_rate @0x0, grid_width @0x4, grid_height @0x8
// A fluid node passes through load, sum, the divider for each velocity component (start,
// 60 quotient bits, done), |u|^2, collision per direction and stream-out. Inlet/outlet adds
// one setup step and a correction per moving direction; a solid node skips |u|^2 and collision.
// Reset is asynchronous and needs no clearing pass; a stalled result holds in the output
// register while the engine waits, and the queue keeps taking requests until full.
// Top level: configuration registers, front end, queue and node engine.
// Depends on lbm_pkg, lbm_front, lbm_fifo, lbm_back.
module lbm_d3q15_collide_stream import lbm_pkg::*; #(
	parameter int FIFO_DEPTH = LBM_FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [7:0]         node_x,
	input  logic [7:0]         node_y,
	input  logic [7:0]         node_z,
	input  logic [3:0]         speed_index,
	input  logic signed [31:0] dist_value,
	input  logic               is_solid,
	input  logic               is_boundary,
	input  logic signed [31:0] bc_velocity,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         dest_x,
	output logic [7:0]         dest_y,
	output logic signed [9:0]  dest_z,
	output logic [3:0]         out_speed,
	output logic signed [31:0] out_value,
	output logic               last
);

	lbm_cfg_t  cfg_q;
	lbm_item_t item_in;
	lbm_item_t push_item;
	lbm_item_t pop_item;
	logic      push, pop, full, empty;
	logic      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relax  <= 30'd268435456;
			cfg_q.width  <= 9'd64;
			cfg_q.height <= 9'd64;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_RELAX:  cfg_q.relax  <= pwdata[29:0];
				REG_WIDTH:  cfg_q.width  <= pwdata[8:0];
				REG_HEIGHT: cfg_q.height <= pwdata[8:0];
				default:    ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[3:2])
			REG_RELAX:  prdata = {2'b00, cfg_q.relax};
			REG_WIDTH:  prdata = {23'd0, cfg_q.width};
			REG_HEIGHT: prdata = {23'd0, cfg_q.height};
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		item_in.node_x   = node_x;
		item_in.node_y   = node_y;
		item_in.node_z   = node_z;
		item_in.speed    = speed_index;
		item_in.value    = dist_value;
		item_in.solid    = is_solid;
		item_in.boundary = is_boundary;
		item_in.bc       = bc_velocity;
		item_in.last     = 1'b0;
	end

	lbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_in    (item_in),
		.push       (push),
		.push_item  (push_item),
		.fifo_full  (full)
	);

	lbm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	lbm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_item     (pop_item),
		.empty        (empty),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.dest_z       (dest_z),
		.out_speed    (out_speed),
		.out_value    (out_value),
		.last         (last)
	);

endmodule

// ===== rtl/lbm_checker.sv =====
// Port-level checks on the result channel of the collide/stream block.
// Depends on nothing; bound to lbm_d3q15_collide_stream at the end of this file.
module lbm_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input logic [3:0]         out_speed,
	input logic signed [31:0] out_value,
	input logic signed [9:0]  dest_z,
	input logic               last
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_value) && $stable(out_speed))
		else $error("stalled result changed");

	// Directions of one node stream out in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last |=>
			!result_valid || (out_speed == $past(out_speed) + 4'd1))
		else $error("result direction out of order");

	// The node closes on its last direction
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == (out_speed == 4'd14)))
		else $error("last flag mismatch");

	// Streamed z stays within one slice of the input range
	a_z: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (dest_z >= -10'sd1) && (dest_z <= 10'sd256))
		else $error("dest_z out of range");

endmodule

bind lbm_d3q15_collide_stream lbm_port_checker u_lbm_checker (.*);

// ===== tb/sv/lbm_checker.sv =====
// Request/result scoreboard for the D3Q15 collide/stream block: snoops config writes,
// predicts each node update and compares every result field. Depends on lbm_pkg.
module lbm_checker import lbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [7:0]         node_x,
	input  logic [7:0]         node_y,
	input  logic [7:0]         node_z,
	input  logic [3:0]         speed_index,
	input  logic signed [31:0] dist_value,
	input  logic               is_solid,
	input  logic               is_boundary,
	input  logic signed [31:0] bc_velocity,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [7:0]         dest_x,
	input  logic [7:0]         dest_y,
	input  logic signed [9:0]  dest_z,
	input  logic [3:0]         out_speed,
	input  logic signed [31:0] out_value,
	input  logic               last,
	output int                 fail_count,
	output int                 pending
);

	localparam longint QONE  = 64'sd268435456;
	localparam longint QMAXL = 64'sd2147483647;
	localparam longint QMINL = -64'sd2147483648;

	typedef struct {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [9:0]  z;
		dir_t        spd;
		logic [31:0] val;
		logic        lst;
	} streamed_t;

	const int ex[15] = '{0, 1, -1, 0, 0, 0, 0, 1, -1, 1, -1, 1, -1, 1, -1};
	const int ey[15] = '{0, 0, 0, 1, -1, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};
	const int ez[15] = '{0, 0, 0, 0, 0, 1, -1, 1, 1, 1, 1, -1, -1, -1, -1};
	const longint wq[15] = '{59652324, 29826162, 29826162, 29826162, 29826162, 29826162,
		29826162, 3728270, 3728270, 3728270, 3728270, 3728270, 3728270, 3728270, 3728270};
	const int opp[15] = '{0, 2, 1, 4, 3, 6, 5, 14, 13, 12, 11, 10, 9, 8, 7};

	streamed_t   streamed_q[$];
	longint      node_f[15];
	logic [7:0]  lat_x, lat_y, lat_z;
	logic        lat_solid, lat_bnd;
	longint      lat_bc;
	logic [29:0] omega_reg;
	logic [8:0]  width_reg, height_reg;

	function automatic longint clamp_q(longint v);
		if (v > QMAXL) return QMAXL;
		if (v < QMINL) return QMINL;
		return v;
	endfunction

	// Product rounded to nearest, ties away from zero
	function automatic longint qmul(longint a, longint b);
		longint p, mag, r;
		p = a * b;
		mag = (p < 0) ? -p : p;
		r = (mag + (64'sd1 <<< 27)) >>> 28;
		return clamp_q((p < 0) ? -r : r);
	endfunction

	function automatic longint qdiv(longint num, longint den);
		if (den == 0) return 0;
		return clamp_q((num * QONE) / den);
	endfunction

	function automatic logic [7:0] wrap(int v, logic [8:0] regv);
		int w;
		w = (regv < 256) ? int'(regv) : 256;
		if (v < 0) v = w - 1;
		else if (v == w) v = 0;
		return v[7:0];
	endfunction

	// Collide the stored node and queue its 15 streamed distributions
	task automatic collide_node();
		longint f[15], g[15];
		longint rho, jx, jy, jz, ux, uy, uz, dx, dy, dz, cu, poly, usq, feq;
		streamed_t s;
		int zz;
		rho = 0; jx = 0; jy = 0; jz = 0;
		for (int k = 0; k < 15; k++) begin
			f[k] = node_f[k];
			rho += f[k];
			jx += ex[k] * f[k];
			jy += ey[k] * f[k];
			jz += ez[k] * f[k];
		end
		rho = clamp_q(rho);
		ux = qdiv(clamp_q(jx), rho);
		uy = qdiv(clamp_q(jy), rho);
		uz = qdiv(clamp_q(jz), rho);
		// inlet/outlet: push toward (0,0,bc)
		if (lat_bnd) begin
			dx = clamp_q(-ux);
			dy = clamp_q(-uy);
			dz = clamp_q(lat_bc - uz);
			for (int k = 1; k < 15; k++) begin
				cu = clamp_q(3 * (ex[k] * dx + ey[k] * dy + ez[k] * dz));
				f[k] = clamp_q(f[k] + qmul(qmul(wq[k], rho), cu));
			end
			ux = 0; uy = 0; uz = lat_bc;
		end
		if (lat_solid) begin
			for (int k = 0; k < 15; k++) g[k] = f[opp[k]];
			f = g;
		end else begin
			usq = clamp_q(qmul(ux, ux) + qmul(uy, uy) + qmul(uz, uz));
			for (int k = 0; k < 15; k++) begin
				cu = clamp_q(3 * (ex[k] * ux + ey[k] * uy + ez[k] * uz));
				poly = clamp_q(QONE + cu + qmul(QONE / 2, qmul(cu, cu))
					- qmul(3 * (QONE / 2), usq));
				feq = qmul(qmul(wq[k], rho), poly);
				f[k] = clamp_q(f[k] - qmul(longint'(omega_reg), clamp_q(f[k] - feq)));
			end
		end
		for (int k = 0; k < 15; k++) begin
			zz = int'(lat_z) + ez[k];
			s.x = wrap(int'(lat_x) + ex[k], width_reg);
			s.y = wrap(int'(lat_y) + ey[k], height_reg);
			s.z = zz[9:0];
			s.spd = dir_t'(k);
			s.val = f[k][31:0];
			s.lst = (k == 14);
			streamed_q.push_back(s);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		streamed_t s;
		if (!arst_n) begin
			omega_reg = 30'd268435456;
			width_reg = 9'd64;
			height_reg = 9'd64;
			for (int k = 0; k < 15; k++) node_f[k] = 0;
			lat_x = '0; lat_y = '0; lat_z = '0;
			lat_solid = 1'b0; lat_bnd = 1'b0; lat_bc = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RELAX:  omega_reg = pwdata[29:0];
					REG_WIDTH:  width_reg = pwdata[8:0];
					REG_HEIGHT: height_reg = pwdata[8:0];
					default: ;
				endcase
			end
			// accepted request: latch, and collide on the closing direction
			if (item_valid && !item_stall && speed_index != DIR_NONE) begin
				node_f[speed_index] = longint'(dist_value);
				lat_x = node_x; lat_y = node_y; lat_z = node_z;
				lat_solid = is_solid; lat_bnd = is_boundary;
				lat_bc = longint'(bc_velocity);
				if (speed_index == DIR_LAST) collide_node();
			end
			// accepted result: compare with oldest prediction
			if (result_valid && !result_stall) begin
				if (streamed_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result dir=%0d value=%h", out_speed, out_value);
					fail_count <= fail_count + 1;
				end else begin
					s = streamed_q.pop_front();
					if (dest_x !== s.x || dest_y !== s.y || dest_z !== s.z ||
					    out_speed !== s.spd || out_value !== s.val || last !== s.lst) begin
						if (fail_count < 10)
							$display("mismatch exp x=%0d y=%0d z=%0d dir=%0d val=%h last=%b %s",
								s.x, s.y, s.z, s.spd, s.val, s.lst, "|");
						if (fail_count < 10)
							$display("         got x=%0d y=%0d z=%0d dir=%0d val=%h last=%b",
								dest_x, dest_y, dest_z[9:0], out_speed, out_value, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= streamed_q.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the collide/stream testbench: clock, reset, config writes, request and
// result stimulus, verdict. Depends on lbm_pkg, lbm_checker and the block itself.
module testbench;
	import lbm_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [7:0]         node_x = '0, node_y = '0, node_z = '0;
	logic [3:0]         speed_index = '0;
	logic signed [31:0] dist_value = '0;
	logic               is_solid = 1'b0, is_boundary = 1'b0;
	logic signed [31:0] bc_velocity = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [7:0]         dest_x, dest_y;
	logic signed [9:0]  dest_z;
	logic [3:0]         out_speed;
	logic signed [31:0] out_value;
	logic               last;
	int                 fail_count, pending;
	int                 sent = 0;
	longint             cycle = 0;

	lbm_d3q15_collide_stream uut (.*);
	lbm_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) cycle <= cycle + 1;

	// Result side: random stall, one long hold-off, one calm window
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			// hold off once while the sender is blocked on a full block
			if (!held && sent >= 80 && item_valid && item_stall) begin
				held = 1'b1;
				hold = 1500;
			end
			if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else if (cycle > 6000 && cycle < 9000) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(0, 99) < 8);
			end
		end
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_grid(logic [29:0] omega, logic [8:0] w, logic [8:0] h);
		reg_write(REG_RELAX, 32'(omega));
		reg_write(REG_WIDTH, 32'(w));
		reg_write(REG_HEIGHT, 32'(h));
	endtask

	// Stop offering, then wait for every predicted result plus the engine's tail
	task automatic drain();
		item_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (450) @(posedge clk);
		@(negedge clk);
	endtask

	// Offer one request; called at a falling edge, returns at a falling edge
	task automatic send(logic [7:0] x, y, z, logic [3:0] dir, logic [31:0] val,
	                    logic sol, bnd, logic [31:0] bc);
		bit calm;
		calm = (sent >= 100 && sent < 140);
		if (!calm && $urandom_range(0, 99) < 8) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		item_valid <= 1'b1;
		node_x <= x; node_y <= y; node_z <= z;
		speed_index <= dir; dist_value <= val;
		is_solid <= sol; is_boundary <= bnd; bc_velocity <= bc;
		do @(posedge clk); while (item_stall);
		if (dir != DIR_NONE) sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_dist(int k);
		int r;
		longint rho, w;
		r = $urandom_range(0, 99);
		w = (k == 0) ? 59652324 : (k < 7) ? 29826162 : 3728270;
		rho = 268435456 + $signed($urandom_range(0, 1 << 27)) - (1 << 26);
		if (r < 85) return 32'((w * rho >>> 28) + $signed($urandom_range(0, 1 << 22)) - (1 << 21));
		if (r < 95) return $urandom;
		case ($urandom_range(0, 2))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			default: return 32'h0;
		endcase
	endfunction

	function automatic logic [31:0] rand_bc();
		if ($urandom_range(0, 9) < 8) return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
		return $urandom;
	endfunction

	// One node: full ordered sweep, shuffled partial update, or with ignored noise
	task automatic send_node();
		logic [7:0]  x, y, z;
		logic        sol, bnd;
		logic [31:0] bc;
		int          mode, n;
		x = 8'($urandom); y = 8'($urandom); z = 8'($urandom);
		if ($urandom_range(0, 3) == 0) x = $urandom_range(0, 1) ? 8'd0 : 8'd255;
		if ($urandom_range(0, 3) == 0) y = $urandom_range(0, 1) ? 8'd0 : 8'd255;
		if ($urandom_range(0, 3) == 0) z = $urandom_range(0, 1) ? 8'd0 : 8'd255;
		sol = ($urandom_range(0, 3) == 0);
		bnd = ($urandom_range(0, 3) == 0);
		bc = rand_bc();
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			for (int k = 0; k < 14; k++) begin
				if ($urandom_range(0, 9) == 0)
					send(8'($urandom), 8'($urandom), 8'($urandom), dir_t'(k), rand_dist(k),
						1'($urandom), 1'($urandom), $urandom);
				else
					send(x, y, z, dir_t'(k), rand_dist(k), sol, bnd, bc);
			end
		end else begin
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++) begin
				int d;
				d = $urandom_range(0, 14);
				send(x, y, z, dir_t'(d), rand_dist(d), sol, bnd, bc);
				if (mode == 9)
					send(8'($urandom), 8'($urandom), 8'($urandom), DIR_NONE, $urandom,
						1'($urandom), 1'($urandom), $urandom);
			end
		end
		send(x, y, z, DIR_LAST, rand_dist(14), sol, bnd, bc);
	endtask

	initial begin
		int nodes;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// narrowest width, tallest height, no relaxation
		set_grid(30'd0, 9'd1, 9'd256);
		// zero density node at the origin, with an ignored direction in the middle
		for (int k = 0; k < 15; k++) begin
			send(8'd0, 8'd0, 8'd0, dir_t'(k), 32'h0, 1'b0, 1'b0, 32'h0);
			if (k == 7)
				send(8'hff, 8'hff, 8'hff, DIR_NONE, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff);
		end
		// solid and boundary together at the far corner
		send(8'd255, 8'd255, 8'd255, DIR_LAST, 32'h7fffffff, 1'b1, 1'b1, 32'h80000000);
		send(8'd255, 8'd0, 8'd255, DIR_LAST, 32'h80000000, 1'b0, 1'b1, 32'h7fffffff);
		send(8'd0, 8'd255, 8'd0, DIR_LAST, 32'h10000000, 1'b1, 1'b0, 32'h0);
		send(8'd63, 8'd63, 8'd1, DIR_LAST, 32'h00e38e39, 1'b0, 1'b0, 32'h0);
		for (int i = 0; i < 2; i++) send_node();
		drain();

		// widest width, shortest height, fastest relaxation
		set_grid(30'd536870912, 9'd256, 9'd1);
		for (int i = 0; i < 3; i++) send_node();

		// random settings until enough requests have gone in
		nodes = 0;
		while (sent < 200) begin
			if (nodes % 4 == 0) begin
				drain();
				set_grid(30'($urandom_range(0, 536870912)), 9'($urandom_range(1, 256)),
					9'($urandom_range(1, 256)));
			end
			send_node();
			nodes++;
		end
		item_valid <= 1'b0;
		drain();

		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
